>>> src/gbsp_pkg.sv
// gbsp_pkg: shared constants, codes and control structs of the grid maze search block
`default_nettype none

package gbsp_pkg;

	// sizes
	localparam int MAX_DIM_DEF = 64;
	localparam int CFG_W       = 7;
	localparam int LEN_W       = 12;

	localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

	// register indexes
	localparam logic REG_HEIGHT = 1'b0;
	localparam logic REG_WIDTH  = 1'b1;

	// request modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// result kinds
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_MOVE    = 1'b1;

	// cell codes
	localparam logic [1:0] CELL_FLOOR = 2'd0;
	localparam logic [1:0] CELL_WALL  = 2'd1;
	localparam logic [1:0] CELL_START = 2'd2;
	localparam logic [1:0] CELL_END   = 2'd3;

	// move codes
	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// accepted request beat toward the engine
	typedef struct packed {
		logic       valid;
		logic       mode;
		logic [1:0] cell_code;
	} gbsp_cmd_t;

	// result handed to the output register
	typedef struct packed {
		logic             kind;
		logic             found;
		logic [LEN_W-1:0] path_length;
		logic [1:0]       direction;
		logic             last_move;
		logic             read_error;
	} gbsp_res_t;

endpackage

`default_nettype wire

>>> src/gbsp_ifs.sv
// gbsp_ifs: valid/ready channel interfaces for requests and results
`default_nettype none

interface gbsp_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [1:0] cell_req;

	modport source (output valid, output mode, output cell_req, input ready);
	modport sink (input valid, input mode, input cell_req, output ready);
	modport monitor (input valid, input ready, input mode, input cell_req);
endinterface

interface gbsp_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic                      found;
	logic [gbsp_pkg::LEN_W-1:0] path_length;
	logic [1:0]                direction;
	logic                      last_move;
	logic                      read_error;

	modport source (output valid, output kind, output found, output path_length,
		output direction, output last_move, output read_error, input ready);
	modport sink (input valid, input kind, input found, input path_length,
		input direction, input last_move, input read_error, output ready);
	modport monitor (input valid, input ready, input kind, input found, input path_length,
		input direction, input last_move, input read_error);
endinterface

`default_nettype wire

>>> src/gbsp_engine.sv
// gbsp_engine: maze storage, breadth-first search sequencer, path trace and move read-out
`default_nettype none

module gbsp_engine #(
	parameter int MAX_DIM = gbsp_pkg::MAX_DIM_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire gbsp_pkg::gbsp_cmd_t         cmd,
	input  wire logic [$clog2(MAX_DIM+1)-1:0] h,
	input  wire logic [$clog2(MAX_DIM+1)-1:0] w,
	input  wire logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] total,
	output logic                             ready,
	output logic                             res_valid,
	output gbsp_pkg::gbsp_res_t              res,
	input  wire logic                        res_take
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int RC_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DM_W  = $clog2(MAX_DIM + 1);
	localparam int QE_W  = IDX_W + 2 * RC_W;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_READ     = 12'b0000_0000_0010,
		S_CLEAR    = 12'b0000_0000_0100,
		S_DIV      = 12'b0000_0000_1000,
		S_SEED     = 12'b0000_0001_0000,
		S_DEQ      = 12'b0000_0010_0000,
		S_POP      = 12'b0000_0100_0000,
		S_PROBE    = 12'b0000_1000_0000,
		S_CHECK    = 12'b0001_0000_0000,
		S_TRACE_RD = 12'b0010_0000_0000,
		S_TRACE    = 12'b0100_0000_0000,
		S_DONE     = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// memories
	logic [1:0]      maze_mem [CELLS];
	logic            vis_mem  [CELLS];
	logic [1:0]      cf_mem   [CELLS];
	logic [QE_W-1:0] q_mem    [CELLS];
	logic [1:0]      path_mem [CELLS];

	logic [1:0]      maze_rd_q;
	logic            vis_rd_q;
	logic [1:0]      cf_rd_q;
	logic [QE_W-1:0] q_rd_q;
	logic [1:0]      path_rd_q;

	// control and working registers
	logic [CNT_W-1:0] load_cnt_q;
	logic             sp_q, ep_q;
	logic [IDX_W-1:0] spos_q, epos_q;
	logic [CNT_W-1:0] head_q, tail_q;
	logic [IDX_W-1:0] cur_q, nb_q, clr_q, rem_q;
	logic [RC_W-1:0]  cr_q, cc_q, nr_q, nc_q, srow_q;
	logic [1:0]       dir_q;
	logic [CNT_W-1:0] len_q, mtot_q, ridx_q;
	logic             rd_last_q;
	gbsp_pkg::gbsp_res_t res_q;

	// combinational helpers
	logic             load_beat, read_beat;
	logic [IDX_W-1:0] load_idx, w_idx, off, nb_sum;
	logic [1:0]       add_sel;
	logic             in_bounds, pass;
	logic             sp_n, ep_n;
	logic [IDX_W-1:0] spos_n, epos_n;
	logic             search_ok, last_cell;
	logic [RC_W-1:0]  nr_n, nc_n;
	logic [IDX_W-1:0] q_idx;
	logic [RC_W-1:0]  q_r, q_c;
	logic [CNT_W-1:0] rd_addr_cnt;

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign load_beat = ready && cmd.valid && (cmd.mode == gbsp_pkg::MODE_LOAD);
	assign read_beat = ready && cmd.valid && (cmd.mode == gbsp_pkg::MODE_READ);
	assign load_idx  = load_cnt_q[IDX_W-1:0];
	assign w_idx     = IDX_W'(w);
	assign last_cell = !((load_cnt_q + CNT_W'(1)) < total);
	assign rd_addr_cnt = mtot_q - ridx_q - CNT_W'(1);
	assign {q_idx, q_r, q_c} = q_rd_q;

	// marker bookkeeping for the cell being loaded
	always_comb begin
		sp_n   = (load_cnt_q == '0) ? 1'b0 : sp_q;
		ep_n   = (load_cnt_q == '0) ? 1'b0 : ep_q;
		spos_n = spos_q;
		epos_n = epos_q;
		if (cmd.cell_code == gbsp_pkg::CELL_START) begin
			sp_n   = 1'b1;
			spos_n = load_idx;
		end else if (cmd.cell_code == gbsp_pkg::CELL_END) begin
			ep_n   = 1'b1;
			epos_n = load_idx;
		end
		search_ok = sp_n && ep_n && (CNT_W'(spos_n) < total) && (CNT_W'(epos_n) < total);
	end

	// shared neighbor address adder: forward step while searching, backward while tracing
	always_comb begin
		add_sel = (state_q == S_TRACE) ? (cf_rd_q ^ gbsp_pkg::DIR_UP) : dir_q;
		case (add_sel)
			gbsp_pkg::DIR_DOWN:  off = w_idx;
			gbsp_pkg::DIR_RIGHT: off = IDX_W'(1);
			gbsp_pkg::DIR_UP:    off = -w_idx;
			gbsp_pkg::DIR_LEFT:  off = '1;
			default:             off = '0;
		endcase
		nb_sum = cur_q + off;
	end

	// bounds check and neighbor row/column
	always_comb begin
		nr_n = cr_q;
		nc_n = cc_q;
		case (dir_q)
			gbsp_pkg::DIR_DOWN: begin
				in_bounds = (DM_W'(cr_q) + DM_W'(1)) < h;
				nr_n      = cr_q + RC_W'(1);
			end
			gbsp_pkg::DIR_RIGHT: begin
				in_bounds = (DM_W'(cc_q) + DM_W'(1)) < w;
				nc_n      = cc_q + RC_W'(1);
			end
			gbsp_pkg::DIR_UP: begin
				in_bounds = (cr_q != '0);
				nr_n      = cr_q - RC_W'(1);
			end
			gbsp_pkg::DIR_LEFT: begin
				in_bounds = (cc_q != '0);
				nc_n      = cc_q - RC_W'(1);
			end
			default: in_bounds = 1'b0;
		endcase
		pass = (maze_rd_q != gbsp_pkg::CELL_WALL) && !vis_rd_q;
	end

	// maze memory: written on load, read when probing
	always_ff @(posedge clk) begin
		if (load_beat) begin
			maze_mem[load_idx] <= cmd.cell_code;
		end else if (state_q == S_PROBE) begin
			maze_rd_q <= maze_mem[nb_sum];
		end
	end

	// visited map: clearing pass, seed, marks and probes
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			vis_mem[clr_q] <= 1'b0;
		end else if (state_q == S_SEED) begin
			vis_mem[spos_q] <= 1'b1;
		end else if (state_q == S_CHECK && pass) begin
			vis_mem[nb_q] <= 1'b1;
		end else if (state_q == S_PROBE) begin
			vis_rd_q <= vis_mem[nb_sum];
		end
	end

	// arrival direction per cell
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK && pass) begin
			cf_mem[nb_q] <= dir_q;
		end else if (state_q == S_TRACE_RD) begin
			cf_rd_q <= cf_mem[cur_q];
		end
	end

	// frontier queue
	always_ff @(posedge clk) begin
		if (state_q == S_SEED) begin
			q_mem[0] <= {spos_q, srow_q, rem_q[RC_W-1:0]};
		end else if (state_q == S_CHECK && pass) begin
			q_mem[tail_q[IDX_W-1:0]] <= {nb_q, nr_q, nc_q};
		end else if (state_q == S_DEQ) begin
			q_rd_q <= q_mem[head_q[IDX_W-1:0]];
		end
	end

	// path moves, stored end first and read back reversed
	always_ff @(posedge clk) begin
		if (state_q == S_TRACE) begin
			path_mem[len_q[IDX_W-1:0]] <= cf_rd_q;
		end else if (read_beat) begin
			path_rd_q <= path_mem[rd_addr_cnt[IDX_W-1:0]];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_cnt_q <= '0;
			sp_q       <= 1'b0;
			ep_q       <= 1'b0;
			spos_q     <= '0;
			epos_q     <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			len_q      <= '0;
			mtot_q     <= '0;
			ridx_q     <= '0;
			dir_q      <= '0;
			cur_q      <= '0;
			nb_q       <= '0;
			clr_q      <= '0;
			rem_q      <= '0;
			cr_q       <= '0;
			cc_q       <= '0;
			nr_q       <= '0;
			nc_q       <= '0;
			srow_q     <= '0;
			rd_last_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (load_beat) begin
						sp_q   <= sp_n;
						ep_q   <= ep_n;
						spos_q <= spos_n;
						epos_q <= epos_n;
						if (!last_cell) begin
							load_cnt_q <= load_cnt_q + CNT_W'(1);
						end else begin
							load_cnt_q <= '0;
							mtot_q     <= '0;
							ridx_q     <= '0;
							head_q     <= '0;
							tail_q     <= '0;
							clr_q      <= '0;
							res_q      <= '0;
							res_q.kind <= gbsp_pkg::KIND_SUMMARY;
							state_q    <= search_ok ? S_CLEAR : S_DONE;
						end
					end else if (read_beat) begin
						res_q      <= '0;
						res_q.kind <= gbsp_pkg::KIND_MOVE;
						if (ridx_q >= mtot_q) begin
							res_q.read_error <= 1'b1;
							state_q          <= S_DONE;
						end else begin
							ridx_q    <= ridx_q + CNT_W'(1);
							rd_last_q <= (ridx_q + CNT_W'(1)) == mtot_q;
							state_q   <= S_READ;
						end
					end
				end
				S_READ: begin
					res_q.direction <= path_rd_q;
					res_q.last_move <= rd_last_q;
					state_q         <= S_DONE;
				end
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if ((CNT_W'(clr_q) + CNT_W'(1)) == total) begin
						rem_q   <= spos_q;
						srow_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// start row and column by repeated subtraction
					if (rem_q >= w_idx) begin
						rem_q  <= rem_q - w_idx;
						srow_q <= srow_q + RC_W'(1);
					end else begin
						state_q <= S_SEED;
					end
				end
				S_SEED: begin
					head_q  <= '0;
					tail_q  <= CNT_W'(1);
					state_q <= S_DEQ;
				end
				S_DEQ: begin
					state_q <= S_POP;
				end
				S_POP: begin
					cur_q  <= q_idx;
					cr_q   <= q_r;
					cc_q   <= q_c;
					head_q <= head_q + CNT_W'(1);
					dir_q  <= gbsp_pkg::DIR_DOWN;
					len_q  <= '0;
					state_q <= (q_idx == epos_q) ? S_TRACE_RD : S_PROBE;
				end
				S_PROBE, S_CHECK: begin
					if (state_q == S_PROBE && in_bounds) begin
						nb_q    <= nb_sum;
						nr_q    <= nr_n;
						nc_q    <= nc_n;
						state_q <= S_CHECK;
					end else begin
						if (state_q == S_CHECK && pass) begin
							tail_q <= tail_q + CNT_W'(1);
						end
						if (dir_q != gbsp_pkg::DIR_LEFT) begin
							dir_q   <= dir_q + 2'd1;
							state_q <= S_PROBE;
						end else if (head_q < tail_q ||
								(state_q == S_CHECK && pass)) begin
							state_q <= S_DEQ;
						end else begin
							// queue ran empty: end unreachable
							state_q <= S_DONE;
						end
					end
				end
				S_TRACE_RD: begin
					if (cur_q == spos_q) begin
						mtot_q            <= len_q;
						res_q.found       <= (len_q != '0);
						res_q.path_length <= gbsp_pkg::LEN_W'(len_q);
						state_q           <= S_DONE;
					end else begin
						state_q <= S_TRACE;
					end
				end
				S_TRACE: begin
					len_q   <= len_q + CNT_W'(1);
					cur_q   <= nb_sum;
					state_q <= S_TRACE_RD;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// queue never hands out more cells than it took
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	// requests arrive only while the sequencer is idle
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> state_q == S_IDLE)
		else $error("request beat while busy");

	// read-out never runs past the stored path
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ridx_q <= mtot_q)
		else $error("read index beyond path");

	// a cell enters the queue at most once, so the queue never overflows
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && pass) |-> tail_q < CNT_W'(CELLS))
		else $error("frontier queue overflow");

endmodule

`default_nettype wire

>>> src/grid_bfs_shortest_path.sv
// grid_bfs_shortest_path: top level with configuration registers and result register
//
// Cells are loaded one per beat in raster order; a load beat that is not the
// last cell leaves the block ready and gives no result. The last cell runs
// the search: a clearing pass over the visited map, a repeated subtraction to
// find the start row and a step to seed the queue, then for every dequeued
// cell a dequeue and a pop, a probe per direction tried and a check per
// in-grid neighbor (single-port maze and visited memories probed one neighbor
// at a time), and finally a trace back over the path in alternating read and
// step states, before the summary is offered. A missing or out-of-grid marker
// skips all of that and goes straight to the summary. A read beat passes
// through a read state that fetches its move; an exhausted read is a read
// error. The request side is not ready while an item is in work; the result
// register lets a new item start while the previous result waits.
`default_nettype none

module grid_bfs_shortest_path #(
	parameter int MAX_DIM = gbsp_pkg::MAX_DIM_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	gbsp_req_if.sink                       req,
	gbsp_rsp_if.source                     rsp,
	input  wire logic                      cfg_wen,
	input  wire logic                      cfg_index,
	input  wire logic [gbsp_pkg::CFG_W-1:0] cfg_data
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int DM_W  = $clog2(MAX_DIM + 1);
	localparam logic [7:0] MAX_DIM8 = 8'(MAX_DIM);

	logic [gbsp_pkg::CFG_W-1:0] h_cfg_q, w_cfg_q;
	logic [DM_W-1:0]            h_eff, w_eff;
	logic [CNT_W-1:0]           total;
	gbsp_pkg::gbsp_cmd_t        cmd;
	gbsp_pkg::gbsp_res_t        eng_res, out_q;
	logic                       eng_ready, eng_res_valid, res_take, out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_cfg_q <= gbsp_pkg::DIM_RESET;
			w_cfg_q <= gbsp_pkg::DIM_RESET;
		end else if (cfg_wen) begin
			if (cfg_index == gbsp_pkg::REG_HEIGHT) begin
				h_cfg_q <= cfg_data;
			end else begin
				w_cfg_q <= cfg_data;
			end
		end
	end

	// effective size: zero acts as one, oversize clamps
	always_comb begin
		if (h_cfg_q == '0) h_eff = DM_W'(1);
		else if ({1'b0, h_cfg_q} > MAX_DIM8) h_eff = DM_W'(MAX_DIM);
		else h_eff = DM_W'(h_cfg_q);
		if (w_cfg_q == '0) w_eff = DM_W'(1);
		else if ({1'b0, w_cfg_q} > MAX_DIM8) w_eff = DM_W'(MAX_DIM);
		else w_eff = DM_W'(w_cfg_q);
		total = CNT_W'(h_eff) * CNT_W'(w_eff);
	end

	// request beat
	assign req.ready     = eng_ready;
	assign cmd.valid     = req.valid && eng_ready;
	assign cmd.mode      = req.mode;
	assign cmd.cell_code = req.cell_req;

	gbsp_engine #(
		.MAX_DIM (MAX_DIM)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.h         (h_eff),
		.w         (w_eff),
		.total     (total),
		.ready     (eng_ready),
		.res_valid (eng_res_valid),
		.res       (eng_res),
		.res_take  (res_take)
	);

	// result register
	assign res_take = eng_res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= eng_res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_q.kind;
	assign rsp.found       = out_q.found;
	assign rsp.path_length = out_q.path_length;
	assign rsp.direction   = out_q.direction;
	assign rsp.last_move   = out_q.last_move;
	assign rsp.read_error  = out_q.read_error;

endmodule

`default_nettype wire

>>> dv/gbsp_maze_checker.sv
// gbsp_maze_checker: watches request and result channels, predicts maze search results and compares
`default_nettype none

module gbsp_maze_checker
	import gbsp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	gbsp_req_if.monitor               req,
	gbsp_rsp_if.monitor               rsp,
	input  wire logic                 cfg_wen,
	input  wire logic                 cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output int                        fail_count,
	output int                        pending_results,
	output int                        summaries_seen,
	output int                        found_seen,
	output int                        moves_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCELL = MAX_DIM_DEF * MAX_DIM_DEF;

	logic [CFG_W-1:0] rows_reg, cols_reg;
	logic [1:0]  maze [NCELL];
	bit          seen [NCELL];
	logic [1:0]  arrived_by [NCELL];
	int          frontier [NCELL];
	logic [1:0]  route [NCELL];
	int          load_pos, route_pos, route_len, start_at, end_at;
	bit          has_start, has_end;
	gbsp_res_t   expected_results [$];

	function automatic int clamp_dim(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
		return int'(v);
	endfunction

	// breadth-first search over the loaded maze, returns path length
	function automatic int search_maze();
		int h, w, total, head, tail, idx, r, c, cur, len, d;
		logic [1:0] t;
		h = clamp_dim(rows_reg);
		w = clamp_dim(cols_reg);
		total = h * w;
		route_len = 0;
		route_pos = 0;
		foreach (seen[i]) seen[i] = 0;
		if (!has_start || !has_end) return 0;
		if (start_at >= total || end_at >= total) return 0;
		seen[start_at] = 1;
		frontier[0] = start_at;
		head = 0;
		tail = 1;
		while (head < tail) begin
			idx = frontier[head];
			r = idx / w;
			c = idx % w;
			head++;
			if (idx == end_at) break;
			for (int k = 0; k < 4; k++) begin
				int nb;
				bit ok;
				case (k)
					0: begin ok = (r + 1 < h); nb = idx + w; end
					1: begin ok = (c + 1 < w); nb = idx + 1; end
					2: begin ok = (r > 0); nb = idx - w; end
					default: begin ok = (c > 0); nb = idx - 1; end
				endcase
				if (ok && nb < NCELL && maze[nb] != CELL_WALL && !seen[nb]) begin
					seen[nb] = 1;
					arrived_by[nb] = 2'(k);
					frontier[tail] = nb;
					tail++;
				end
			end
		end
		if (!seen[end_at]) return 0;
		// walk back from the end, then reverse
		cur = end_at;
		len = 0;
		while (cur != start_at && len < total) begin
			d = arrived_by[cur];
			route[len] = 2'(d);
			len++;
			case (2'(d))
				DIR_DOWN:  cur -= w;
				DIR_RIGHT: cur -= 1;
				DIR_UP:    cur += w;
				default:   cur += 1;
			endcase
			if (cur >= total || cur < 0) return 0;
		end
		for (int k = 0; k < len / 2; k++) begin
			t = route[k];
			route[k] = route[len - 1 - k];
			route[len - 1 - k] = t;
		end
		route_len = len;
		return len;
	endfunction

	// work out the result of one accepted request beat
	task automatic predict_beat(logic m, logic [1:0] cell_in);
		gbsp_res_t res;
		int total, idx, len;
		res = '0;
		if (m == MODE_LOAD) begin
			total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
			idx = load_pos;
			if (idx >= NCELL) idx = NCELL - 1;
			if (idx == 0) begin
				has_start = 0;
				has_end = 0;
			end
			maze[idx] = cell_in;
			if (cell_in == CELL_START) begin
				start_at = idx;
				has_start = 1;
			end else if (cell_in == CELL_END) begin
				end_at = idx;
				has_end = 1;
			end
			if (idx + 1 < total) begin
				load_pos = idx + 1;
				return;
			end
			load_pos = 0;
			len = search_maze();
			res.kind = KIND_SUMMARY;
			res.found = (len > 0);
			res.path_length = LEN_W'(len);
		end else begin
			res.kind = KIND_MOVE;
			if (route_pos >= route_len) begin
				res.read_error = 1'b1;
			end else begin
				res.direction = route[route_pos];
				route_pos++;
				res.last_move = (route_pos == route_len);
			end
		end
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		gbsp_res_t want;
		if (!arst_n) begin
			rows_reg <= DIM_RESET;
			cols_reg <= DIM_RESET;
			load_pos = 0;
			route_pos = 0;
			route_len = 0;
			start_at = 0;
			end_at = 0;
			has_start = 0;
			has_end = 0;
			fail_count = 0;
			summaries_seen = 0;
			found_seen = 0;
			moves_seen = 0;
			expected_results.delete();
			pending_results = 0;
		end else begin
			// register writes
			if (cfg_wen) begin
				if (cfg_index == REG_HEIGHT) rows_reg <= cfg_data;
				else cols_reg <= cfg_data;
			end
			// result beat against oldest expectation
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result beat, kind", rsp.kind, -1);
				end else begin
					want = expected_results.pop_front();
					if (rsp.kind !== want.kind) report_mismatch("kind", rsp.kind, want.kind);
					if (rsp.found !== want.found) report_mismatch("found", rsp.found, want.found);
					if (rsp.path_length !== want.path_length)
						report_mismatch("path_length", rsp.path_length, want.path_length);
					if (rsp.direction !== want.direction)
						report_mismatch("direction", rsp.direction, want.direction);
					if (rsp.last_move !== want.last_move)
						report_mismatch("last_move", rsp.last_move, want.last_move);
					if (rsp.read_error !== want.read_error)
						report_mismatch("read_error", rsp.read_error, want.read_error);
					if (want.kind == KIND_SUMMARY) begin
						summaries_seen++;
						if (want.found) found_seen++;
					end else if (!want.read_error) begin
						moves_seen++;
					end
				end
			end
			// request beat updates the prediction
			if (req.valid && req.ready) predict_beat(req.mode, req.cell_req);
			pending_results = expected_results.size();
		end
	end
endmodule

`default_nettype wire

>>> dv/tb_grid_bfs_shortest_path.sv
// tb_grid_bfs_shortest_path: stimulus, configuration phases and verdict for the maze search block
`default_nettype none

module tb_grid_bfs_shortest_path;
	import gbsp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic cfg_index = REG_HEIGHT;
	logic [CFG_W-1:0] cfg_data = '0;
	int   fail_count, pending_results, summaries_seen, found_seen, moves_seen;
	int   sender_idle_pct = 0;
	int   receiver_stall_pct = 0;
	int   beats_sent = 0;
	int   rows_now = 64, cols_now = 64;

	gbsp_req_if req ();
	gbsp_rsp_if rsp ();

	grid_bfs_shortest_path dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gbsp_maze_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req(req.monitor), .rsp(rsp.monitor),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_results(pending_results),
		.summaries_seen(summaries_seen), .found_seen(found_seen), .moves_seen(moves_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.mode = MODE_LOAD;
		req.cell_req = CELL_FLOOR;
		rsp.ready = 1'b0;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// one request beat, with random idle cycles ahead of it
	task automatic send_beat(logic m, logic [1:0] cell_in);
		while ($urandom_range(99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.cell_req <= cell_in;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_size(logic [CFG_W-1:0] h, logic [CFG_W-1:0] w);
		drain();
		write_reg(REG_HEIGHT, h);
		write_reg(REG_WIDTH, w);
		cfg_wen <= 1'b0;
		rows_now = (h == 0) ? 1 : (h > 64 ? 64 : h);
		cols_now = (w == 0) ? 1 : (w > 64 ? 64 : w);
	endtask

	// load a random maze: one start, one end, walls at some density, sometimes broken
	task automatic load_maze(int wall_pct);
		int n, s, e;
		logic [1:0] c;
		n = rows_now * cols_now;
		s = $urandom_range(n - 1);
		e = $urandom_range(n - 1);
		for (int i = 0; i < n; i++) begin
			c = ($urandom_range(99) < wall_pct) ? CELL_WALL : CELL_FLOOR;
			if ($urandom_range(99) < 3) c = 2'($urandom_range(3));
			if (i == s) c = CELL_START;
			if (i == e && $urandom_range(9) != 0) c = CELL_END;
			send_beat(MODE_LOAD, c);
		end
	endtask

	task automatic read_moves(int extra);
		int k;
		k = $urandom_range(0, 14) + extra;
		for (int i = 0; i < k; i++) send_beat(MODE_READ, 2'($urandom_range(3)));
	endtask

	initial begin
		int phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of size and special cases
		set_size(7'd0, 7'd0);
		send_beat(MODE_LOAD, CELL_START);
		send_beat(MODE_READ, CELL_FLOOR);
		set_size(7'd1, 7'd2);
		send_beat(MODE_LOAD, CELL_START);
		send_beat(MODE_LOAD, CELL_END);
		send_beat(MODE_READ, CELL_WALL);
		send_beat(MODE_READ, CELL_END);
		set_size(7'd2, 7'd2);
		send_beat(MODE_LOAD, CELL_END);
		send_beat(MODE_LOAD, CELL_WALL);
		send_beat(MODE_LOAD, CELL_WALL);
		send_beat(MODE_LOAD, CELL_START);
		send_beat(MODE_READ, CELL_START);
		set_size(7'd1, 7'd3);
		send_beat(MODE_LOAD, CELL_START);
		send_beat(MODE_LOAD, CELL_START);
		send_beat(MODE_LOAD, CELL_END);
		read_moves(1);
		// size shrinks while loading: the load completes at the smaller size with no end marker
		set_size(7'd2, 7'd3);
		send_beat(MODE_LOAD, CELL_START);
		send_beat(MODE_LOAD, CELL_FLOOR);
		set_size(7'd1, 7'd3);
		send_beat(MODE_LOAD, CELL_FLOOR);
		set_size(7'd127, 7'd1);
		load_maze(0);
		read_moves(64);

		// random phases over sizes and idling patterns
		phase = 0;
		while (beats_sent < 700) begin
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
				default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
			endcase
			if (phase == 1) set_size(7'd64, 7'd1);
			else if (phase == 3) set_size(7'd1, 7'd100);
			else set_size(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
			repeat ((phase == 1 || phase == 3) ? 1 : 4) begin
				load_maze($urandom_range(0, 35));
				read_moves(rows_now + cols_now);
			end
			phase++;
		end
		// a larger maze once, sparse walls
		sender_idle_pct = 0;
		receiver_stall_pct = 19;
		set_size(7'd12, 7'd12);
		load_maze(5);
		read_moves(30);
		drain();

		$display("covered %0d request beats, %0d searches (%0d found), %0d path moves",
			beats_sent, summaries_seen, found_seen, moves_seen);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule

`default_nettype wire
